// ===== sv/selective_background_subtraction_unit_assert.svh =====
// Assertion macros shared by the background subtraction modules.
`ifndef SELECTIVE_BACKGROUND_SUBTRACTION_UNIT_ASSERT_SVH
`define SELECTIVE_BACKGROUND_SUBTRACTION_UNIT_ASSERT_SVH

// Checked property that is switched off while reset is asserted.
`define SBSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked property that must also hold during reset.
`define SBSU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/sbsu_pkg.sv =====
// Package with the types, codes and defaults of the background subtraction unit.
package sbsu_pkg;

  // Default sizing of the pixel grid and of the stored fraction.
  localparam int GRID_PIXELS_DEF   = 4800;
  localparam int FRACTION_BITS_DEF = 6;

  // Command codes.
  localparam logic [1:0] CMD_SEED    = 2'd0;
  localparam logic [1:0] CMD_COMPARE = 2'd1;
  localparam logic [1:0] CMD_UPDATE  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_FG_THRESHOLD    = 2'd0;
  localparam logic [1:0] REG_ALPHA_NORMAL    = 2'd1;
  localparam logic [1:0] REG_ALPHA_PROTECTED = 2'd2;
  localparam logic [1:0] REG_GC_LIMIT        = 2'd3;

  // Configuration reset values.
  localparam logic [7:0]  FG_THRESHOLD_RST    = 8'd20;
  localparam logic [15:0] ALPHA_NORMAL_RST    = 16'd3277;
  localparam logic [15:0] ALPHA_PROTECTED_RST = 16'd164;
  localparam logic [12:0] GC_LIMIT_RST        = 13'd2400;

  // The foreground count saturates here.
  localparam logic [12:0] COUNT_MAX = 13'h1FFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [12:0] pixel_index;
    logic [7:0]  pixel_value;
    logic        protect;
  } item_t;

  typedef struct packed {
    logic        foreground;
    logic [7:0]  background_level;
    logic [12:0] motion_count;
    logic        global_change;
  } result_t;

  typedef struct packed {
    logic [7:0]  fg_threshold;
    logic [15:0] alpha_normal;
    logic [15:0] alpha_protected;
    logic [12:0] global_change_limit;
  } cfg_t;

  // Fill level of the result queue and whether a word leaves it this cycle.
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } outq_status_t;

endpackage

// ===== sv/sbsu_ifs.sv =====
// Valid/ready channel interfaces for pixel commands and results.
interface sbsu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [12:0] pixel_index;
  logic [7:0]  pixel_value;
  logic        protect;

  modport source (output valid, command, pixel_index, pixel_value, protect, input ready);
  modport sink (input valid, command, pixel_index, pixel_value, protect, output ready);
endinterface

interface sbsu_out_if;
  logic        valid;
  logic        ready;
  logic        foreground;
  logic [7:0]  background_level;
  logic [12:0] motion_count;
  logic        global_change;

  modport source (output valid, foreground, background_level, motion_count, global_change,
                  input ready);
  modport sink (input valid, foreground, background_level, motion_count, global_change,
                output ready);
endinterface

// ===== sv/sbsu_ram.sv =====
// Generic single-write, single-read RAM with registered read data (read-first).
module sbsu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; a same-edge write is not seen.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sbsu_core.sv =====
// Pixel stage: background lookup with write forwarding, compare, blend and count.
`include "selective_background_subtraction_unit_assert.svh"

module sbsu_core #(
  parameter int GRID_PIXELS   = sbsu_pkg::GRID_PIXELS_DEF,
  parameter int FRACTION_BITS = sbsu_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sbsu_pkg::cfg_t                   cfg_i,
  input  logic                             accept_i,
  input  sbsu_pkg::item_t                  item_i,
  output logic                             rd_en_o,
  output logic [$clog2(GRID_PIXELS)-1:0]   rd_addr_o,
  input  logic [8+FRACTION_BITS-1:0]       rd_data_i,
  output logic                             wr_en_o,
  output logic [$clog2(GRID_PIXELS)-1:0]   wr_addr_o,
  output logic [8+FRACTION_BITS-1:0]       wr_data_o,
  output logic                             push_o,
  output sbsu_pkg::result_t                result_o
);

  localparam int AddrW = $clog2(GRID_PIXELS);
  localparam int EntryW = 8 + FRACTION_BITS;
  localparam int Shift = 16 - FRACTION_BITS;
  localparam int RW = 9 + FRACTION_BITS;
  localparam int SumW = RW + 2;
  localparam logic [24:0] RoundHalf = 25'(1) << (Shift - 1);
  localparam logic signed [SumW-1:0] EntryMaxS = SumW'((32'd1 << EntryW) - 32'd1);

  logic              s1_valid_q;
  sbsu_pkg::item_t   s1_item_q;
  logic              s1_inrange_q;
  logic              fwd_valid_q;
  logic [12:0]       fwd_idx_q;
  logic [EntryW-1:0] fwd_data_q;
  logic [12:0]       cnt_q, cnt_d;

  logic                   acc_inrange;
  logic [EntryW-1:0]      entry;
  logic [7:0]             b_lvl;
  logic                   pix_ge;
  logic [7:0]             diff;
  logic                   fg;
  logic [15:0]            alpha;
  logic [23:0]            prod;
  logic [24:0]            rsum;
  logic [RW-1:0]          r_mag;
  logic signed [SumW-1:0] base_s, r_s, nv_s;
  logic [EntryW-1:0]      blend_val;
  logic [EntryW-1:0]      new_entry;
  logic [EntryW-1:0]      lvl_entry;
  logic [12:0]            cnt_base;

  // Read request in the cycle the word is accepted.
  assign acc_inrange = 32'(item_i.pixel_index) < 32'(GRID_PIXELS);
  assign rd_en_o = accept_i && acc_inrange;
  assign rd_addr_o = AddrW'(item_i.pixel_index);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_item_q    <= item_i;
      s1_inrange_q <= acc_inrange;
    end
  end

  // The RAM read misses the write made on the same edge, so that write is kept aside.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= wr_en_o;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_idx_q  <= s1_item_q.pixel_index;
    fwd_data_q <= wr_data_o;
  end

  // Current background entry; out-of-grid pixels read as zero.
  always_comb begin
    if (!s1_inrange_q) begin
      entry = '0;
    end else if (fwd_valid_q && (fwd_idx_q == s1_item_q.pixel_index)) begin
      entry = fwd_data_q;
    end else begin
      entry = rd_data_i;
    end
  end

  // Integer background and absolute difference to the pixel.
  assign b_lvl = entry[EntryW-1:FRACTION_BITS];
  assign pix_ge = s1_item_q.pixel_value >= b_lvl;
  assign diff = pix_ge ? (s1_item_q.pixel_value - b_lvl) : (b_lvl - s1_item_q.pixel_value);
  assign fg = (s1_item_q.command == sbsu_pkg::CMD_COMPARE) && (diff >= cfg_i.fg_threshold);

  // Blend: scaled step rounded half away from zero, then clamped to the entry range.
  assign alpha = s1_item_q.protect ? cfg_i.alpha_protected : cfg_i.alpha_normal;
  assign prod = 24'(alpha) * 24'(diff);
  assign rsum = {1'b0, prod} + RoundHalf;
  assign r_mag = RW'(rsum >> Shift);
  assign base_s = signed'(SumW'(b_lvl) << FRACTION_BITS);
  assign r_s = signed'(SumW'(r_mag));
  assign nv_s = pix_ge ? (base_s + r_s) : (base_s - r_s);

  always_comb begin
    if (nv_s[SumW-1]) begin
      blend_val = '0;
    end else if (nv_s > EntryMaxS) begin
      blend_val = '1;
    end else begin
      blend_val = EntryW'(nv_s);
    end
  end

  // New entry by command.
  always_comb begin
    case (s1_item_q.command)
      sbsu_pkg::CMD_SEED:   new_entry = EntryW'(s1_item_q.pixel_value) << FRACTION_BITS;
      sbsu_pkg::CMD_UPDATE: new_entry = blend_val;
      default:              new_entry = entry;
    endcase
  end

  assign wr_en_o = s1_valid_q && s1_inrange_q &&
                   (s1_item_q.command inside {sbsu_pkg::CMD_SEED, sbsu_pkg::CMD_UPDATE});
  assign wr_addr_o = AddrW'(s1_item_q.pixel_index);
  assign wr_data_o = new_entry;
  assign lvl_entry = wr_en_o ? new_entry : entry;

  // Foreground count: restarts at the first pixel of a pass and saturates.
  always_comb begin
    cnt_base = (s1_item_q.pixel_index == '0) ? '0 : cnt_q;
    cnt_d = cnt_q;
    if (s1_valid_q && (s1_item_q.command == sbsu_pkg::CMD_COMPARE)) begin
      cnt_d = (fg && (cnt_base != sbsu_pkg::COUNT_MAX)) ? cnt_base + 13'd1 : cnt_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Result word for the output queue.
  assign push_o = s1_valid_q;
  assign result_o.foreground = fg;
  assign result_o.background_level = lvl_entry[EntryW-1:FRACTION_BITS];
  assign result_o.motion_count = cnt_d;
  assign result_o.global_change = cnt_d > cfg_i.global_change_limit;

  // A compare inside a pass never lowers the count.
  `SBSU_ASSERT(a_count_monotonic, (s1_valid_q && (s1_item_q.command == sbsu_pkg::CMD_COMPARE) && (s1_item_q.pixel_index != 13'd0)) |=> (cnt_q >= $past(cnt_q)), "foreground count fell inside a pass")

endmodule

// ===== sv/sbsu_outq.sv =====
// Two-word result queue that decouples the pixel stage from output stalls.
module sbsu_outq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  sbsu_pkg::result_t      data_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output sbsu_pkg::result_t      data_o,
  output sbsu_pkg::outq_status_t status_o
);

  sbsu_pkg::result_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign valid_o = count_q != 2'd0;
  assign pop = valid_o && ready_i;
  assign data_o = slot_q[rd_ptr_q];

  // Storage for queued words.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop);
    end
  end

  assign status_o.count = count_q;
  assign status_o.pop = pop;

endmodule

// ===== sv/selective_background_subtraction_unit.sv =====
// Top level of the selective running-average background subtraction unit.
//
//   channel  direction  word
//   px_i     in         command, pixel_index, pixel_value, protect
//   res_o    out        foreground, background_level, motion_count, global_change
//   cfg      in         cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One word is accepted per cycle while px_i.ready is high; its result enters
// the queue in the next cycle and is registered there before leaving on res_o.
// The path is set by the background RAM read, the forwarding mux and one
// 16x8 multiply with rounding and clamp between the input and queue registers.
// Reset clears control state and the foreground count; the background store is
// not cleared and must be seeded. A two-word result queue absorbs output stalls;
// px_i.ready drops only when that queue would otherwise overflow.
`include "selective_background_subtraction_unit_assert.svh"

module selective_background_subtraction_unit #(
  parameter int GRID_PIXELS   = sbsu_pkg::GRID_PIXELS_DEF,
  parameter int FRACTION_BITS = sbsu_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbsu_in_if.sink     px_i,
  sbsu_out_if.source  res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int AddrW = $clog2(GRID_PIXELS);
  localparam int EntryW = 8 + FRACTION_BITS;

  sbsu_pkg::cfg_t         cfg_q;
  sbsu_pkg::item_t        item;
  sbsu_pkg::result_t      core_res;
  sbsu_pkg::result_t      q_res;
  sbsu_pkg::outq_status_t q_st;
  logic                   accept;
  logic                   push;
  logic                   rd_en, wr_en;
  logic [AddrW-1:0]       rd_addr, wr_addr;
  logic [EntryW-1:0]      rd_data, wr_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fg_threshold        <= sbsu_pkg::FG_THRESHOLD_RST;
      cfg_q.alpha_normal        <= sbsu_pkg::ALPHA_NORMAL_RST;
      cfg_q.alpha_protected     <= sbsu_pkg::ALPHA_PROTECTED_RST;
      cfg_q.global_change_limit <= sbsu_pkg::GC_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sbsu_pkg::REG_FG_THRESHOLD:    cfg_q.fg_threshold <= cfg_data_i[7:0];
        sbsu_pkg::REG_ALPHA_NORMAL:    cfg_q.alpha_normal <= cfg_data_i;
        sbsu_pkg::REG_ALPHA_PROTECTED: cfg_q.alpha_protected <= cfg_data_i;
        sbsu_pkg::REG_GC_LIMIT:        cfg_q.global_change_limit <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Input word; accept only when the queue can take every word in flight.
  assign item.command     = px_i.command;
  assign item.pixel_index = px_i.pixel_index;
  assign item.pixel_value = px_i.pixel_value;
  assign item.protect     = px_i.protect;
  assign px_i.ready = (3'(q_st.count) + 3'(push)) <= (3'd1 + 3'(q_st.pop));
  assign accept = px_i.valid && px_i.ready;

  // Background store.
  sbsu_ram #(
    .Width (EntryW),
    .Depth (GRID_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Pixel stage.
  sbsu_core #(
    .GRID_PIXELS   (GRID_PIXELS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (accept),
    .item_i    (item),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .push_o    (push),
    .result_o  (core_res)
  );

  // Result queue.
  sbsu_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (core_res),
    .valid_o  (res_o.valid),
    .ready_i  (res_o.ready),
    .data_o   (q_res),
    .status_o (q_st)
  );

  assign res_o.foreground       = q_res.foreground;
  assign res_o.background_level = q_res.background_level;
  assign res_o.motion_count     = q_res.motion_count;
  assign res_o.global_change    = q_res.global_change;

  // A full queue is only pushed when a word leaves in the same cycle.
  `SBSU_ASSERT(a_queue_no_overflow, (push && (q_st.count == 2'd2)) |-> q_st.pop, "result queue overflow")
  // Input back-pressure only comes from words waiting in the queue.
  `SBSU_ASSERT_ALWAYS(a_stall_needs_backlog, (!px_i.ready) |-> (q_st.count != 2'd0), "input stalled with empty queue")
  // Every accepted word reaches the queue on the next cycle.
  `SBSU_ASSERT(a_accept_pushes, accept |=> push, "accepted word did not reach the queue")

endmodule
